/* rtl/core/tvc_pkg.sv */
`default_nettype none

package tvc_pkg;

  localparam int SCREEN_COLS_DEF = 84;
  localparam int SCREEN_ROWS_DEF = 48;
  localparam int COEF_SLOTS      = 48;
  localparam int COEF_AW         = 6;
  localparam int ONE_Q8          = 256;
  localparam int CAM_Z           = 1024;
  localparam int DVD_W           = 49;
  localparam int DVS_W           = 34;
  localparam int QMAG_W          = 48;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CULL_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CULL_THRESHOLD = 1'd1;

  typedef struct packed {
    logic               kind;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] screen_x1;
    logic signed [15:0] screen_y1;
    logic signed [15:0] screen_x2;
    logic signed [15:0] screen_y2;
    logic signed [15:0] screen_x3;
    logic signed [15:0] screen_y3;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOADV, ST_MAC, ST_NEXT, ST_CROSS, ST_MAG, ST_FIT, ST_DOT,
    ST_NORM, ST_SQRT, ST_CDIV, ST_CCHK, ST_SCRX, ST_SCRXW, ST_SCRY, ST_SCRYW,
    ST_OUT
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -50'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
    logic signed [23:0] r;
    if (v > 43'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -43'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tvc_coef_mem.sv */
`default_nettype none

module tvc_coef_mem (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [tvc_pkg::COEF_AW-1:0] waddr_i,
  input  wire logic signed [15:0]          wdata_i,
  input  wire logic [tvc_pkg::COEF_AW-1:0] raddr_i,
  output logic signed [15:0]               rdata_o
);
  import tvc_pkg::*;

  logic signed [15:0] mem_q [COEF_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/tvc_isqrt.sv */
`default_nettype none

module tvc_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  import tvc_pkg::*;

  logic        busy_q, done_q;
  logic [63:0] num_q, res_q, bit_q, sum;

  assign sum    = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= rad_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (num_q >= sum) begin
        num_q <= num_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tvc_div.sv */
`default_nettype none

module tvc_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [tvc_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic signed [tvc_pkg::DVS_W-1:0]  divisor_i,
  output logic                                   done_o,
  output logic signed [tvc_pkg::DVD_W-1:0]       quotient_o
);
  import tvc_pkg::*;

  localparam int CNT_W = $clog2(QMAG_W);

  logic                    busy_q, done_q, neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [DVS_W-1:0]        rem_q, rem_sh, dvs_q;
  logic [QMAG_W-1:0]       quo_q;
  logic [DVD_W-1:0]        dvd_abs;
  logic [DVS_W-1:0]        dvs_abs;
  logic                    last;

  assign dvd_abs = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
  assign dvs_abs = divisor_i[DVS_W-1] ? DVS_W'(-divisor_i) : DVS_W'(divisor_i);
  assign rem_sh  = {rem_q[DVS_W-2:0], quo_q[QMAG_W-1]};
  assign last    = (cnt_q == CNT_W'(QMAG_W - 1));
  assign done_o  = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_abs[QMAG_W-1:0];
      dvs_q <= dvs_abs;
      neg_q <= dividend_i[DVD_W-1] ^ divisor_i[DVS_W-1];
    end else if (busy_q) begin
      if (rem_sh >= dvs_q) begin
        rem_q <= rem_sh - dvs_q;
        quo_q <= {quo_q[QMAG_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QMAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/triangle_vertex_transform_cull_top.sv */
// Triangle vertex transform, back-face cull and screen projection.
// Input channel (in_valid_i/in_ready_o/in_data_i): a transfer either loads
// one matrix coefficient (model 0-15, view 16-31, projection 32-47) or
// presents one vertex. Coefficient and first/second vertex transfers are
// accepted without a stall. The third vertex starts the triangle and the
// input stalls until it is finished.
// Model and view transform each corner in turn (load, then two 4x4 passes
// of multiply-accumulate, each followed by a step). Culling then computes
// the cross product, normalizing shifts, dot and norms, a 32-step square
// root and a 48-step divide; the divide is skipped when the normal or the
// view direction is zero. Projection runs a 4x4 pass and two 48-step
// divides per corner, for column and row. A culled triangle returns to
// idle without projection.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per drawn
// triangle, held in an output register; the next triangle is processed
// while it waits and stalls only when its own result is ready.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i at once.
// Reset clears the vertex count, enables culling with threshold zero and
// empties the output; coefficients are undefined until loaded.
`default_nettype none

module triangle_vertex_transform_cull_top #(
  parameter int SCREEN_COLS = tvc_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tvc_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire tvc_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output tvc_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tvc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tvc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tvc_pkg::*;

  state_e state_q, state_d;

  logic               in_acc, out_free;
  logic [1:0]         vcnt_q;
  logic               out_valid_q;
  logic               cull_en_q;
  logic signed [15:0] cull_thr_q;
  logic               rd_vld_q;
  logic [4:0]         cnt_q;
  logic [3:0]         e_q;
  logic [3:0]         step_q;
  logic [1:0]         vk_q, pass_q;

  vtx_t               held_q [2];
  vtx_t               v3_q, vsel, vin;
  logic signed [23:0] src_q [4];
  logic signed [23:0] res_q [4];
  logic signed [23:0] pv_q [3][4];
  logic signed [42:0] acc_q, acc_new;
  logic signed [50:0] n_q [3];
  logic signed [24:0] d_q [3];
  logic [50:0]        nm_q [3];
  logic [24:0]        dm_q [3];
  logic signed [24:0] av [3];
  logic signed [24:0] bv [3];
  logic signed [33:0] dot_q;
  logic [31:0]        nn_q, dd_q;
  logic signed [15:0] cos_q;
  logic signed [15:0] sx_q [3];
  logic signed [15:0] sy_q [3];
  out_item_t          out_q;

  logic               mem_we;
  logic [COEF_AW-1:0] mem_raddr;
  logic signed [15:0] mem_rdata;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic               div_start, div_done;
  logic signed [DVD_W-1:0] div_dvd, div_quo;
  logic signed [DVS_W-1:0] div_dvs;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  logic signed [23:0] qw;
  logic signed [24:0] xq, yq, q2;
  logic               nbig, dbig;
  logic signed [49:0] row_full;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign vin         = '{x: in_data_i.vertex_x, y: in_data_i.vertex_y, z: in_data_i.vertex_z};
  assign mem_we      = in_acc && (in_data_i.kind == KIND_COEF) &&
                       (in_data_i.coef_index < COEF_AW'(COEF_SLOTS));
  assign mem_raddr   = {pass_q, cnt_q[3:0]};

  tvc_coef_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_data_i.coef_index),
    .wdata_i (in_data_i.coef_value),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  tvc_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (mul_p[63:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av[i] = 25'(pv_q[1][i]) - 25'(pv_q[0][i]);
      bv[i] = 25'(pv_q[2][i]) - 25'(pv_q[0][i]);
    end
  end

  assign qw   = (res_q[3] != 24'sd0) ? res_q[3] : 24'(ONE_Q8);
  assign xq   = 25'(res_q[0]) + 25'(qw);
  assign yq   = 25'(res_q[1]) + 25'(qw);
  assign q2   = 25'(qw) <<< 1;
  assign nbig = (nm_q[0][50:15] != '0) || (nm_q[1][50:15] != '0) ||
                (nm_q[2][50:15] != '0);
  assign dbig = (dm_q[0][24:15] != '0) || (dm_q[1][24:15] != '0) ||
                (dm_q[2][24:15] != '0);
  assign row_full = 50'(SCREEN_ROWS) - 50'(div_quo);

  assign mul_p   = mul_a * mul_b;
  assign acc_new = ((e_q[1:0] == 2'd0) ? 43'sd0 : acc_q) + $signed(mul_p[42:0]);

  always_comb begin
    vsel = v3_q;
    case (vk_q)
      2'd0:    vsel = held_q[0];
      2'd1:    vsel = held_q[1];
      default: vsel = v3_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.kind == KIND_VERTEX && vcnt_q == 2'd2) begin
          state_d = ST_LOADV;
        end
      end
      ST_LOADV: state_d = ST_MAC;
      ST_MAC: begin
        if (cnt_q[4]) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        case (pass_q)
          2'd0: state_d = ST_MAC;
          2'd1: begin
            if (vk_q != 2'd2) begin
              state_d = ST_LOADV;
            end else if (cull_en_q) begin
              state_d = ST_CROSS;
            end else begin
              state_d = ST_MAC;
            end
          end
          2'd2:    state_d = ST_SCRX;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CROSS: begin
        if (step_q == 4'd5) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: state_d = ST_FIT;
      ST_FIT: begin
        if (!nbig && !dbig) begin
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        if (step_q == 4'd8) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) begin
          state_d = (sq_root == '0) ? ST_CCHK : ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          state_d = ST_CCHK;
        end
      end
      ST_CCHK:  state_d = (cos_q < cull_thr_q) ? ST_IDLE : ST_MAC;
      ST_SCRX:  state_d = ST_SCRXW;
      ST_SCRXW: begin
        if (div_done) begin
          state_d = ST_SCRY;
        end
      end
      ST_SCRY:  state_d = ST_SCRYW;
      ST_SCRYW: begin
        if (div_done) begin
          state_d = (vk_q == 2'd2) ? ST_OUT : ST_MAC;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    sq_start   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MAC: begin
        mul_a = 33'(mem_rdata);
        mul_b = 33'(src_q[e_q[1:0]]);
      end
      ST_CROSS: begin
        case (step_q)
          4'd0:    begin mul_a = 33'(av[1]); mul_b = 33'(bv[2]); end
          4'd1:    begin mul_a = 33'(av[2]); mul_b = 33'(bv[1]); end
          4'd2:    begin mul_a = 33'(av[2]); mul_b = 33'(bv[0]); end
          4'd3:    begin mul_a = 33'(av[0]); mul_b = 33'(bv[2]); end
          4'd4:    begin mul_a = 33'(av[0]); mul_b = 33'(bv[1]); end
          4'd5:    begin mul_a = 33'(av[1]); mul_b = 33'(bv[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_DOT: begin
        case (step_q)
          4'd0: begin
            mul_a = 33'($signed(n_q[0][15:0])); mul_b = 33'($signed(d_q[0][15:0]));
          end
          4'd1: begin
            mul_a = 33'($signed(n_q[1][15:0])); mul_b = 33'($signed(d_q[1][15:0]));
          end
          4'd2: begin
            mul_a = 33'($signed(n_q[2][15:0])); mul_b = 33'($signed(d_q[2][15:0]));
          end
          4'd3: begin
            mul_a = 33'($signed(n_q[0][15:0])); mul_b = 33'($signed(n_q[0][15:0]));
          end
          4'd4: begin
            mul_a = 33'($signed(n_q[1][15:0])); mul_b = 33'($signed(n_q[1][15:0]));
          end
          4'd5: begin
            mul_a = 33'($signed(n_q[2][15:0])); mul_b = 33'($signed(n_q[2][15:0]));
          end
          4'd6: begin
            mul_a = 33'($signed(d_q[0][15:0])); mul_b = 33'($signed(d_q[0][15:0]));
          end
          4'd7: begin
            mul_a = 33'($signed(d_q[1][15:0])); mul_b = 33'($signed(d_q[1][15:0]));
          end
          4'd8: begin
            mul_a = 33'($signed(d_q[2][15:0])); mul_b = 33'($signed(d_q[2][15:0]));
          end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_NORM: begin
        mul_a    = $signed({1'b0, nn_q});
        mul_b    = $signed({1'b0, dd_q});
        sq_start = 1'b1;
      end
      ST_SQRT: begin
        div_start = sq_done && (sq_root != '0);
        div_dvd   = DVD_W'(dot_q) <<< 15;
        div_dvs   = $signed({2'b00, sq_root});
      end
      ST_SCRX: begin
        mul_a     = 33'(xq);
        mul_b     = 33'(SCREEN_COLS);
        div_start = 1'b1;
        div_dvd   = $signed(mul_p[DVD_W-1:0]);
        div_dvs   = DVS_W'(q2);
      end
      ST_SCRY: begin
        mul_a     = 33'(yq);
        mul_b     = 33'(SCREEN_ROWS);
        div_start = 1'b1;
        div_dvd   = $signed(mul_p[DVD_W-1:0]);
        div_dvs   = DVS_W'(q2);
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      cull_en_q   <= 1'b1;
      cull_thr_q  <= '0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_MAC) && !cnt_q[4];
      cnt_q    <= (state_q == ST_MAC) ? cnt_q + 1'b1 : '0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CULL_ENABLE:    cull_en_q  <= cfg_data_i[0];
          CFG_CULL_THRESHOLD: cull_thr_q <= $signed(cfg_data_i);
          default:            cull_en_q  <= cull_en_q;
        endcase
      end
      if (in_acc && in_data_i.kind == KIND_VERTEX) begin
        vcnt_q <= (vcnt_q == 2'd2) ? 2'd0 : vcnt_q + 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= cnt_q[3:0];
    case (state_q)
      ST_IDLE: begin
        vk_q <= '0;
        if (in_acc && in_data_i.kind == KIND_VERTEX) begin
          if (vcnt_q == 2'd2) begin
            v3_q <= vin;
          end else begin
            held_q[vcnt_q[0]] <= vin;
          end
        end
      end
      ST_LOADV: begin
        src_q[0] <= 24'(vsel.x);
        src_q[1] <= 24'(vsel.y);
        src_q[2] <= 24'(vsel.z);
        src_q[3] <= 24'(ONE_Q8);
        pass_q   <= 2'd0;
      end
      ST_MAC: begin
        if (rd_vld_q) begin
          acc_q <= acc_new;
          if (e_q[1:0] == 2'd3) begin
            res_q[e_q[3:2]] <= sat24(acc_new >>> 12);
          end
        end
      end
      ST_NEXT: begin
        step_q <= '0;
        case (pass_q)
          2'd0: begin
            src_q  <= res_q;
            pass_q <= 2'd1;
          end
          2'd1: begin
            pv_q[vk_q] <= res_q;
            if (vk_q != 2'd2) begin
              vk_q <= vk_q + 1'b1;
            end else begin
              vk_q   <= '0;
              src_q  <= pv_q[0];
              pass_q <= 2'd2;
            end
          end
          default: pass_q <= pass_q;
        endcase
      end
      ST_CROSS: begin
        step_q <= step_q + 1'b1;
        if (step_q[0]) begin
          n_q[step_q[2:1]] <= n_q[step_q[2:1]] - 51'($signed(mul_p[49:0]));
        end else begin
          n_q[step_q[2:1]] <= 51'($signed(mul_p[49:0]));
        end
        if (step_q == 4'd0) begin
          d_q[0] <= 25'sd0 - 25'(pv_q[0][0]);
          d_q[1] <= 25'sd0 - 25'(pv_q[0][1]);
          d_q[2] <= 25'(CAM_Z) - 25'(pv_q[0][2]);
        end
      end
      ST_MAG: begin
        step_q <= '0;
        for (int i = 0; i < 3; i++) begin
          nm_q[i] <= n_q[i][50] ? 51'(-n_q[i]) : 51'(n_q[i]);
          dm_q[i] <= d_q[i][24] ? 25'(-d_q[i]) : 25'(d_q[i]);
        end
      end
      ST_FIT: begin
        for (int i = 0; i < 3; i++) begin
          if (nbig) begin
            n_q[i]  <= n_q[i] >>> 1;
            nm_q[i] <= nm_q[i] >> 1;
          end
          if (dbig) begin
            d_q[i]  <= d_q[i] >>> 1;
            dm_q[i] <= dm_q[i] >> 1;
          end
        end
      end
      ST_DOT: begin
        step_q <= step_q + 1'b1;
        case (step_q)
          4'd0:             dot_q <= 34'(mul_p);
          4'd1, 4'd2:       dot_q <= dot_q + 34'(mul_p);
          4'd3:             nn_q  <= mul_p[31:0];
          4'd4, 4'd5:       nn_q  <= nn_q + mul_p[31:0];
          4'd6:             dd_q  <= mul_p[31:0];
          4'd7, 4'd8:       dd_q  <= dd_q + mul_p[31:0];
          default:          dot_q <= dot_q;
        endcase
      end
      ST_SQRT: begin
        if (sq_done && sq_root == '0) begin
          cos_q <= '0;
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          cos_q <= sat16(50'(div_quo));
        end
      end
      ST_CCHK: begin
        vk_q   <= '0;
        src_q  <= pv_q[0];
        pass_q <= 2'd2;
      end
      ST_SCRXW: begin
        if (div_done) begin
          sx_q[vk_q] <= sat16(50'(div_quo));
        end
      end
      ST_SCRYW: begin
        if (div_done) begin
          sy_q[vk_q] <= sat16(row_full);
          if (vk_q != 2'd2) begin
            vk_q  <= vk_q + 1'b1;
            src_q <= pv_q[vk_q + 1'b1];
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_q <= '{screen_x1: sx_q[0], screen_y1: sy_q[0],
                     screen_x2: sx_q[1], screen_y2: sy_q[1],
                     screen_x3: sx_q[2], screen_y3: sy_q[2]};
        end
      end
      default: vk_q <= vk_q;
    endcase
  end

endmodule

`default_nettype wire
